[rtl/core/pbpm_pkg.sv]
package pbpm_pkg;

  // Field widths
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned DESC_W = 4;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned DESC_COUNT = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ATTACH   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DETACH   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_TRIM     = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SET_LEN  = 3'd6;
  localparam logic [REQ_W-1:0] REQ_FREE_BUF = 3'd7;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_BUF   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_DESC  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_POOL = 2'd3;

  // Configuration register indexes
  localparam logic CFG_POOL_BASE = 1'b0;
  localparam logic CFG_STRIDE    = 1'b1;

  // One descriptor table entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  trimmed;
  } desc_entry_t;

endpackage

[rtl/core/pbpm_if.sv]
// Request channel
interface pbpm_req_if;
  logic                          valid;
  logic                          ready;
  logic [pbpm_pkg::REQ_W-1:0]    req_type;
  logic [pbpm_pkg::DESC_W-1:0]   desc_index;
  logic [pbpm_pkg::ADDR_W-1:0]   buf_address;
  logic [pbpm_pkg::LEN_W-1:0]    byte_count;

  modport source (output valid, req_type, desc_index, buf_address, byte_count,
                  input ready);
  modport sink   (input valid, req_type, desc_index, buf_address, byte_count,
                  output ready);
endinterface

// Result channel
interface pbpm_res_if;
  logic                          valid;
  logic                          ready;
  logic [pbpm_pkg::STAT_W-1:0]   status;
  logic [pbpm_pkg::DESC_W-1:0]   desc_out;
  logic [pbpm_pkg::ADDR_W-1:0]   data_address;
  logic [pbpm_pkg::LEN_W-1:0]    remaining_length;

  modport source (output valid, status, desc_out, data_address, remaining_length,
                  input ready);
  modport sink   (input valid, status, desc_out, data_address, remaining_length,
                  output ready);
endinterface

[rtl/core/packet_buffer_pool_manager.sv]
// Channel   Direction  Handshake      Payload
// in_req    in         valid/ready    req_type, desc_index, buf_address, byte_count
// out_res   out        valid/ready    status, desc_out, data_address, remaining_length
// cfg_*     in         write enable   cfg_index, cfg_wdata
//
// Most requests pass through accept, table read-modify-write and result load.
// Release and free-by-address add a buffer address scan, one pool buffer
// compared per cycle against a running base + x * stride.
// The descriptor table is a one-port-write, registered-read memory; per-entry
// valid bits make unwritten entries read as zero, so reset needs no clearing pass.
// A waiting result in the output register does not block the next transfer in.
module packet_buffer_pool_manager #(
  parameter int unsigned POOL_SIZE = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pbpm_req_if.sink                        in_req,
  pbpm_res_if.source                      out_res,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [pbpm_pkg::ADDR_W-1:0]     cfg_wdata
);

  localparam int unsigned BUF_IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned PROD_W = BUF_IW + pbpm_pkg::LEN_W;
  localparam int unsigned DESC_W = pbpm_pkg::DESC_W;
  localparam int unsigned ADDR_W = pbpm_pkg::ADDR_W;
  localparam int unsigned LEN_W  = pbpm_pkg::LEN_W;

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]                     state_r;
  logic [ADDR_W-1:0]              base_r;
  logic [LEN_W-1:0]               stride_r;

  logic [POOL_SIZE-1:0]           buf_busy_r;
  logic [pbpm_pkg::DESC_COUNT-1:0] desc_busy_r;
  logic [pbpm_pkg::DESC_COUNT-1:0] desc_vld_r;

  // Latched request
  logic [pbpm_pkg::REQ_W-1:0]     req_r;
  logic [DESC_W-1:0]              di_r;
  logic [ADDR_W-1:0]              addr_in_r;
  logic [LEN_W-1:0]               cnt_r;
  logic [BUF_IW-1:0]              fb_idx_r;
  logic                           fb_found_r;
  logic [DESC_W-1:0]              fd_idx_r;
  logic                           fd_found_r;
  logic [PROD_W-1:0]              prod_r;

  // Descriptor memory
  pbpm_pkg::desc_entry_t          mem [pbpm_pkg::DESC_COUNT];
  pbpm_pkg::desc_entry_t          mem_q_r;
  logic                           vld_q_r;
  logic                           mem_we;
  logic [DESC_W-1:0]              mem_widx;
  pbpm_pkg::desc_entry_t          mem_wdata;
  pbpm_pkg::desc_entry_t          ent;

  // Entry after update, for reports
  pbpm_pkg::desc_entry_t          ent_r;
  logic                           report_r;

  // Scan
  logic [ADDR_W-1:0]              target_r;
  logic [ADDR_W-1:0]              cur_r;
  logic [BUF_IW-1:0]              x_r;

  // Pending result
  logic [pbpm_pkg::STAT_W-1:0]    res_status_r;
  logic [DESC_W-1:0]              res_desc_r;
  logic [ADDR_W-1:0]              res_addr_r;
  logic [LEN_W-1:0]               res_len_r;
  logic [pbpm_pkg::STAT_W-1:0]    res_status_nxt;
  logic [DESC_W-1:0]              res_desc_nxt;
  logic [ADDR_W-1:0]              res_addr_nxt;
  logic [LEN_W-1:0]               res_len_nxt;

  // Output register
  logic                           out_valid_r;
  logic [pbpm_pkg::STAT_W-1:0]    out_status_r;
  logic [DESC_W-1:0]              out_desc_r;
  logic [ADDR_W-1:0]              out_addr_r;
  logic [LEN_W-1:0]               out_len_r;

  logic                           in_xfer;
  logic                           out_free;
  logic [BUF_IW-1:0]              fb_idx;
  logic                           fb_found;
  logic [DESC_W-1:0]              fd_idx;
  logic                           fd_found;
  logic                           rep_over;
  logic [ADDR_W-1:0]              rep_addr;
  logic [LEN_W-1:0]               rep_len;
  logic [ADDR_W-1:0]              alloc_addr;

  assign in_xfer   = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_res.ready;

  // Lowest free pool buffer
  always_comb begin
    fb_idx   = '0;
    fb_found = 1'b0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (!buf_busy_r[i]) begin
        fb_idx   = BUF_IW'(i);
        fb_found = 1'b1;
      end
    end
  end

  // Lowest free descriptor
  always_comb begin
    fd_idx   = '0;
    fd_found = 1'b0;
    for (int i = pbpm_pkg::DESC_COUNT - 1; i >= 0; i--) begin
      if (!desc_busy_r[i]) begin
        fd_idx   = DESC_W'(i);
        fd_found = 1'b1;
      end
    end
  end

  // Entry as read; never-written entries read as zero
  assign ent        = vld_q_r ? mem_q_r : '0;
  assign alloc_addr = base_r + ADDR_W'(prod_r);

  // Table write during the read-modify-write cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_widx  = di_r;
    mem_wdata = ent;
    if (state_r == ST_EXEC) begin
      unique case (req_r)
        pbpm_pkg::REQ_ALLOC: begin
          mem_we    = fb_found_r && fd_found_r;
          mem_widx  = fd_idx_r;
          mem_wdata = '{addr: alloc_addr, len: '0, trimmed: '0};
        end
        pbpm_pkg::REQ_ATTACH: begin
          mem_we    = fd_found_r;
          mem_widx  = fd_idx_r;
          mem_wdata = '{addr: addr_in_r, len: cnt_r, trimmed: '0};
        end
        pbpm_pkg::REQ_TRIM: begin
          mem_we            = 1'b1;
          mem_wdata.trimmed = ent.trimmed + cnt_r;
        end
        pbpm_pkg::REQ_SET_LEN: begin
          mem_we        = 1'b1;
          mem_wdata.len = cnt_r;
        end
        pbpm_pkg::REQ_RELEASE, pbpm_pkg::REQ_DETACH,
        pbpm_pkg::REQ_QUERY, pbpm_pkg::REQ_FREE_BUF: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // Reply fields decided in the read-modify-write cycle
  always_comb begin
    res_status_nxt = pbpm_pkg::ST_OK;
    res_desc_nxt   = di_r;
    res_addr_nxt   = '0;
    res_len_nxt    = '0;
    if (state_r == ST_EXEC) begin
      unique case (req_r)
        pbpm_pkg::REQ_ALLOC: begin
          if (!fb_found_r) begin
            res_status_nxt = pbpm_pkg::ST_NO_BUF;
            res_desc_nxt   = '0;
          end else if (!fd_found_r) begin
            res_status_nxt = pbpm_pkg::ST_NO_DESC;
            res_desc_nxt   = '0;
          end else begin
            res_desc_nxt = fd_idx_r;
            res_addr_nxt = alloc_addr;
          end
        end
        pbpm_pkg::REQ_ATTACH: begin
          if (!fd_found_r) begin
            res_status_nxt = pbpm_pkg::ST_NO_DESC;
            res_desc_nxt   = '0;
          end else begin
            res_desc_nxt = fd_idx_r;
            res_addr_nxt = addr_in_r;
            res_len_nxt  = cnt_r;
          end
        end
        pbpm_pkg::REQ_DETACH: begin
          res_addr_nxt = ent.addr;
        end
        pbpm_pkg::REQ_FREE_BUF: begin
          res_desc_nxt = '0;
        end
        pbpm_pkg::REQ_RELEASE, pbpm_pkg::REQ_QUERY,
        pbpm_pkg::REQ_TRIM, pbpm_pkg::REQ_SET_LEN: begin
          res_desc_nxt = di_r;
        end
      endcase
    end
  end

  // Descriptor memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
    mem_q_r <= mem[in_req.desc_index];
  end

  // Report view of the updated entry
  assign rep_over = ent_r.trimmed > ent_r.len;
  assign rep_addr = ent_r.addr + (rep_over ? '0 : ADDR_W'(ent_r.trimmed));
  assign rep_len  = rep_over ? '0 : (ent_r.len - ent_r.trimmed);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      stride_r <= LEN_W'(1536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pbpm_pkg::CFG_POOL_BASE: base_r   <= cfg_wdata;
        pbpm_pkg::CFG_STRIDE:    stride_r <= cfg_wdata[LEN_W-1:0];
      endcase
    end
  end

  // Request capture and multiply for the allocation address
  always_ff @(posedge clk) begin
    vld_q_r <= desc_vld_r[in_req.desc_index];
    if (in_xfer) begin
      req_r      <= in_req.req_type;
      di_r       <= in_req.desc_index;
      addr_in_r  <= in_req.buf_address;
      cnt_r      <= in_req.byte_count;
      fb_idx_r   <= fb_idx;
      fb_found_r <= fb_found;
      fd_idx_r   <= fd_idx;
      fd_found_r <= fd_found;
      prod_r     <= {{LEN_W{1'b0}}, fb_idx} * {{BUF_IW{1'b0}}, stride_r};
    end
  end

  // Sequencer and table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      buf_busy_r  <= '0;
      desc_busy_r <= '0;
      desc_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Result register fills on load, empties on a transfer out
      if (state_r == ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (mem_we) begin
        desc_vld_r[mem_widx] <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          ent_r        <= mem_wdata;
          report_r     <= (req_r == pbpm_pkg::REQ_QUERY) || (req_r == pbpm_pkg::REQ_TRIM) ||
                          (req_r == pbpm_pkg::REQ_SET_LEN);
          res_status_r <= res_status_nxt;
          res_desc_r   <= res_desc_nxt;
          res_addr_r   <= res_addr_nxt;
          res_len_r    <= res_len_nxt;
          target_r     <= (req_r == pbpm_pkg::REQ_RELEASE) ? ent.addr : addr_in_r;
          cur_r        <= base_r;
          x_r          <= '0;
          state_r      <= (req_r == pbpm_pkg::REQ_RELEASE || req_r == pbpm_pkg::REQ_FREE_BUF) ?
                          ST_SCAN : ST_RESULT;
          unique case (req_r)
            pbpm_pkg::REQ_ALLOC: begin
              if (fb_found_r && fd_found_r) begin
                buf_busy_r[fb_idx_r]  <= 1'b1;
                desc_busy_r[fd_idx_r] <= 1'b1;
              end
            end
            pbpm_pkg::REQ_ATTACH: begin
              if (fd_found_r) begin
                desc_busy_r[fd_idx_r] <= 1'b1;
              end
            end
            pbpm_pkg::REQ_RELEASE, pbpm_pkg::REQ_DETACH: begin
              desc_busy_r[di_r] <= 1'b0;
              desc_vld_r[di_r]  <= 1'b0;
            end
            pbpm_pkg::REQ_QUERY, pbpm_pkg::REQ_TRIM, pbpm_pkg::REQ_SET_LEN,
            pbpm_pkg::REQ_FREE_BUF: begin
            end
          endcase
        end
        ST_SCAN: begin
          // One pool buffer per cycle; lowest match wins
          if (cur_r == target_r) begin
            buf_busy_r[x_r] <= 1'b0;
            res_status_r    <= pbpm_pkg::ST_OK;
            state_r         <= ST_RESULT;
          end else if (x_r == BUF_IW'(POOL_SIZE - 1)) begin
            res_status_r <= (target_r != '0) ? pbpm_pkg::ST_NOT_POOL : pbpm_pkg::ST_OK;
            state_r      <= ST_RESULT;
          end else begin
            x_r   <= x_r + 1'b1;
            cur_r <= cur_r + ADDR_W'(stride_r);
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Output payload load
  always_ff @(posedge clk) begin
    if (state_r == ST_RESULT && out_free) begin
      out_status_r <= res_status_r;
      out_desc_r   <= res_desc_r;
      out_addr_r   <= report_r ? rep_addr : res_addr_r;
      out_len_r    <= report_r ? rep_len : res_len_r;
    end
  end

  assign out_res.valid            = out_valid_r;
  assign out_res.status           = out_status_r;
  assign out_res.desc_out         = out_desc_r;
  assign out_res.data_address     = out_addr_r;
  assign out_res.remaining_length = out_len_r;

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_EXEC)
    else $error("transfer in did not start the table access");

  a_scan_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |->
      (req_r == pbpm_pkg::REQ_RELEASE || req_r == pbpm_pkg::REQ_FREE_BUF))
    else $error("buffer scan entered for a request that frees nothing");

  a_busy_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (desc_busy_r & ~desc_vld_r) == '0)
    else $error("descriptor in use without a written table entry");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> desc_vld_r[$past(mem_widx)])
    else $error("table write did not mark its entry valid");

endmodule
